// ===== sv/r2b_pkg.sv =====
// Shared types, constants and the header byte table of the RGB565 to BMP24 stream encoder.
package r2b_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam int unsigned HDR_BYTES  = 54;
	localparam int unsigned INFO_BYTES = 40;
	localparam int unsigned BPP        = 24;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_SWAP_BYTES   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       hdr;
		logic [1:0] pad;
		logic       frame_end;
	} item_t;

	typedef struct packed {
		logic [26:0] img_size;
		logic [12:0] width;
		logic [12:0] height;
	} geom_t;

	function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input geom_t g);
		logic [31:0] word;
		logic [1:0]  sel;
		logic [7:0]  res;
		word = 32'd0;
		sel  = idx[1:0] - 2'd2;
		res  = 8'd0;
		case (idx) inside
			6'd0:                  res = 8'h42;
			6'd1:                  res = 8'h4D;
			[6'd2:6'd5]:           word = 32'(HDR_BYTES) + {5'd0, g.img_size};
			6'd10:                 res = 8'(HDR_BYTES);
			6'd14:                 res = 8'(INFO_BYTES);
			[6'd18:6'd21]:         word = {19'd0, g.width};
			[6'd22:6'd25]:         word = 32'd0 - {19'd0, g.height};
			6'd26:                 res = 8'd1;
			6'd28:                 res = 8'(BPP);
			[6'd34:6'd37]:         word = {5'd0, g.img_size};
			default:               res = 8'd0;
		endcase
		if ((idx >= 6'd2 && idx <= 6'd5) || (idx >= 6'd18 && idx <= 6'd25) ||
				(idx >= 6'd34 && idx <= 6'd37)) begin
			res = word[{sel, 3'b000} +: 8];
		end
		return res;
	endfunction

endpackage

// ===== sv/r2b_byte_seq.sv =====
// Byte sequencer: walks header, pixel and pad bytes of one item into a registered byte output.
module r2b_byte_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  r2b_pkg::item_t item,
	input  r2b_pkg::geom_t geom,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast,
	output logic           m_tuser
);

	logic           busy_q;
	logic [5:0]     idx_q;
	r2b_pkg::item_t item_s2;
	logic           m_valid_q;
	logic [7:0]     m_data_q;
	logic           m_last_q;
	logic           m_user_q;

	logic           emit;
	logic           last_byte;
	logic [7:0]     byte_val;

	assign emit       = busy_q && (!m_valid_q || m_tready);
	assign last_byte  = idx_q == (6'd56 + {4'd0, item_s2.pad});
	assign item_ready = !busy_q || (emit && last_byte);

	always_comb begin
		case (idx_q) inside
			[6'd0:6'd53]: byte_val = r2b_pkg::hdr_byte(idx_q, geom);
			6'd54:        byte_val = item_s2.blue;
			6'd55:        byte_val = item_s2.green;
			6'd56:        byte_val = item_s2.red;
			default:      byte_val = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= 6'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				busy_q <= 1'b1;
				idx_q  <= item.hdr ? 6'd0 : 6'd54;
			end else if (emit) begin
				if (last_byte) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 6'd1;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s2 <= item;
		end
		if (emit) begin
			m_data_q <= byte_val;
			m_last_q <= last_byte;
			m_user_q <= last_byte && item_s2.frame_end;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

endmodule

// ===== sv/rgb565_to_bmp24_stream_top.sv =====
// Top level of the RGB565 to 24-bit top-down BMP stream encoder.
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata = pixel (RGB565)
// m_*       out  m_tvalid/m_tready   m_tdata = out_byte, m_tlast = run_last, m_tuser = frame_last
// apb       in   psel/penable/pready frame_width, frame_height, swap_bytes at 0x0, 0x4, 0x8
//
// One output byte leaves per cycle while m_tready is high; a pixel is 3 bytes, 3 + pad at a row end and
// 54 more for the header on the first pixel of a frame, all set by the byte sequencer.
// A new pixel is taken into the input register while the previous one is still being sent.
// Reset clears the counters and the handshake state and loads the register defaults.
// A stalled m_tready holds the output byte and backs up into s_tready after one pixel.
module rgb565_to_bmp24_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [12:0]    frame_width_q;
	logic [12:0]    frame_height_q;
	logic           swap_bytes_q;
	logic [11:0]    col_q;
	logic [11:0]    row_q;
	r2b_pkg::geom_t geom_q;
	r2b_pkg::item_t item_s1;
	logic           s1_valid_q;

	logic           cfg_wr;
	logic [12:0]    w_eff;
	logic [12:0]    h_eff;
	logic [13:0]    line_bytes;
	logic [1:0]     pad;
	logic [13:0]    stride;
	logic [15:0]    px;
	logic           row_end;
	logic           frame_end;
	logic           s_accept;
	logic           seq_ready;
	r2b_pkg::item_t item_d;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 13'd320;
			frame_height_q <= 13'd240;
			swap_bytes_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				r2b_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[12:0];
				r2b_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[12:0];
				r2b_pkg::REG_SWAP_BYTES:   swap_bytes_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			r2b_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_q};
			r2b_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_q};
			r2b_pkg::REG_SWAP_BYTES:   prdata = {31'd0, swap_bytes_q};
			default:                   prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (frame_width_q == 13'd0) begin
			w_eff = 13'd1;
		end else if (frame_width_q > 13'(r2b_pkg::MAX_WIDTH)) begin
			w_eff = 13'(r2b_pkg::MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q == 13'd0) begin
			h_eff = 13'd1;
		end else if (frame_height_q > 13'(r2b_pkg::MAX_HEIGHT)) begin
			h_eff = 13'(r2b_pkg::MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	assign line_bytes = {1'b0, w_eff} + {w_eff, 1'b0};
	assign pad        = 2'd0 - line_bytes[1:0];
	assign stride     = line_bytes + {12'd0, pad};

	always_ff @(posedge clk) begin
		geom_q.img_size <= {13'd0, stride} * {14'd0, h_eff};
		geom_q.width    <= w_eff;
		geom_q.height   <= h_eff;
	end

	assign px        = swap_bytes_q ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;
	assign row_end   = ({1'b0, col_q} + 13'd1) >= w_eff;
	assign frame_end = row_end && (({1'b0, row_q} + 13'd1) >= h_eff);

	always_comb begin
		item_d.red       = {px[15:11], px[15:13]};
		item_d.green     = {px[10:5], px[10:9]};
		item_d.blue      = {px[4:0], px[4:2]};
		item_d.hdr       = (col_q == 12'd0) && (row_q == 12'd0);
		item_d.pad       = row_end ? pad : 2'd0;
		item_d.frame_end = frame_end;
	end

	assign s_tready = !s1_valid_q || seq_ready;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= 12'd0;
			row_q      <= 12'd0;
			s1_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				s1_valid_q <= 1'b1;
				if (row_end) begin
					col_q <= 12'd0;
					row_q <= frame_end ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 12'd1;
				end
			end else if (seq_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_d;
		end
	end

	r2b_byte_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s1_valid_q),
		.item_ready (seq_ready),
		.item       (item_s1),
		.geom       (geom_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	a_user_implies_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame_last without run_last");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_q)
		else $error("input stalled with empty input register");

	a_header_on_origin: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && col_q == 12'd0 && row_q == 12'd0 |=> s1_valid_q && item_s1.hdr)
		else $error("first pixel of frame lost its header flag");

endmodule

// ===== tb/sv/tb_rgb565_to_bmp24_stream_top.sv =====
// Self-checking testbench for the RGB565 to 24-bit BMP stream encoder top level.
module tb_rgb565_to_bmp24_stream_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       frame_last;
	} bmp_byte_t;

	localparam int         WATCHDOG_CYCLES = 2000;
	localparam int         SETTLE_CYCLES   = 8;
	localparam int         PRINT_CAP       = 100;
	localparam logic [3:0] ADDR_WIDTH      = {r2b_pkg::REG_FRAME_WIDTH, 2'b00};
	localparam logic [3:0] ADDR_HEIGHT     = {r2b_pkg::REG_FRAME_HEIGHT, 2'b00};
	localparam logic [3:0] ADDR_SWAP       = {r2b_pkg::REG_SWAP_BYTES, 2'b00};
	localparam logic [3:0] ADDR_UNMAPPED   = 4'hC;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	bit          idling_on = 1'b1;
	int          ready_hold = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int          bytes_checked = 0;

	logic [12:0] cfg_width = 13'd320;
	logic [12:0] cfg_height = 13'd240;
	logic        cfg_swap = 1'b0;
	int unsigned col_next = 0;
	int unsigned row_next = 0;
	bmp_byte_t   bytes_due[$];

	rgb565_to_bmp24_stream_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned maxv);
		if (v == 13'd0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic void encode_pixel(input logic [15:0] px);
		int unsigned  w;
		int unsigned  h;
		int unsigned  pad;
		int unsigned  img;
		logic [431:0] hdr;
		logic [15:0]  p;
		logic [7:0]   seq[$];
		bit           row_end;
		bit           frame_end;
		bmp_byte_t    e;
		w   = clamp_dim(cfg_width, r2b_pkg::MAX_WIDTH);
		h   = clamp_dim(cfg_height, r2b_pkg::MAX_HEIGHT);
		pad = (4 - ((w * 3) & 3)) & 3;
		img = (w * 3 + pad) * h;
		if (col_next == 0 && row_next == 0) begin
			hdr = {128'd0, img, 32'd0, 8'd0, 8'(r2b_pkg::BPP), 8'd0, 8'd1, 32'd0 - h, w,
				32'(r2b_pkg::INFO_BYTES), 32'(r2b_pkg::HDR_BYTES), 32'd0,
				32'(r2b_pkg::HDR_BYTES) + img, 8'h4D, 8'h42};
			for (int k = 0; k < r2b_pkg::HDR_BYTES; k++) seq.push_back(hdr[k*8 +: 8]);
		end
		p = cfg_swap ? {px[7:0], px[15:8]} : px;
		seq.push_back({p[4:0], p[4:2]});
		seq.push_back({p[10:5], p[10:9]});
		seq.push_back({p[15:11], p[15:13]});
		row_end   = (col_next + 1 >= w);
		frame_end = row_end && (row_next + 1 >= h);
		if (row_end) begin
			repeat (pad) seq.push_back(8'd0);
			col_next = 0;
			row_next = frame_end ? 0 : row_next + 1;
		end else begin
			col_next = col_next + 1;
		end
		foreach (seq[i]) begin
			e.data       = seq[i];
			e.run_last   = (i == seq.size() - 1);
			e.frame_last = e.run_last && frame_end;
			bytes_due.push_back(e);
		end
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s wrong at byte %0d: got 0x%0h, expected 0x%0h",
				$realtime, field, bytes_checked, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		bmp_byte_t want;
		if (!arst_n) begin
			cfg_width  = 13'd320;
			cfg_height = 13'd240;
			cfg_swap   = 1'b0;
			col_next   = 0;
			row_next   = 0;
			bytes_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					r2b_pkg::REG_FRAME_WIDTH:  cfg_width = pwdata[12:0];
					r2b_pkg::REG_FRAME_HEIGHT: cfg_height = pwdata[12:0];
					r2b_pkg::REG_SWAP_BYTES:   cfg_swap = pwdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (bytes_due.size() == 0) begin
					report_mismatch("unexpected out_byte", m_tdata, 0);
				end else begin
					want = bytes_due.pop_front();
					if (m_tdata !== want.data) report_mismatch("out_byte", m_tdata, want.data);
					if (m_tlast !== want.run_last) report_mismatch("run_last", m_tlast, want.run_last);
					if (m_tuser !== want.frame_last)
						report_mismatch("frame_last", m_tuser, want.frame_last);
				end
				bytes_checked++;
			end
			if (s_tvalid && s_tready) encode_pixel(s_tdata);
		end
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready   <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 12);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_CYCLES) begin
			$display("rgb565_to_bmp24_stream_top verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [15:0] px);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [3:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic cfg_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [31:0] w, input logic [31:0] h, input logic sw);
		cfg_write(ADDR_WIDTH, w);
		cfg_write(ADDR_HEIGHT, h);
		cfg_write(ADDR_SWAP, {31'd0, sw});
		cfg_release();
	endtask

	task automatic test_reset_defaults();
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		wait_drained();
	endtask

	task automatic test_color_extremes();
		set_geometry(1, 1, 1'b0);
		send_pixel(16'hF800);
		send_pixel(16'h07E0);
		send_pixel(16'h001F);
		send_pixel(16'h0000);
		wait_drained();
		set_geometry(1, 1, 1'b1);
		send_pixel(16'h00F8);
		send_pixel(16'hE007);
		send_pixel(16'h1F00);
		send_pixel(16'hA5C3);
		wait_drained();
	endtask

	task automatic test_row_padding();
		int w;
		for (w = 2; w <= 4; w++) begin
			set_geometry((w == 3) ? 32'hFFFF_E003 : w, 1, 1'b0);
			repeat (w) send_pixel(16'($urandom()));
			wait_drained();
		end
	endtask

	task automatic test_dimension_limits();
		set_geometry(0, 0, 1'b0);
		send_pixel(16'h8421);
		wait_drained();
		set_geometry(32'd8191, 32'd8191, 1'b1);
		cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		cfg_release();
		repeat (3) send_pixel(16'($urandom()));
		wait_drained();
		set_geometry(2, 4096, 1'b0);
		repeat (2) send_pixel(16'($urandom()));
		wait_drained();
		set_geometry(4096, 1, 1'b1);
		send_pixel(16'($urandom()));
		wait_drained();
	endtask

	task automatic test_random_frames();
		int          sent;
		int          n;
		int          pick;
		logic [31:0] w;
		logic [31:0] h;
		sent = 0;
		while (sent < 240) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) w = 4096;
			else if (pick == 1) w = 0;
			else if (pick == 2) w = $urandom_range(4097, 8191);
			else w = $urandom_range(1, 9);
			pick = $urandom_range(0, 19);
			if (pick == 0) h = 4096;
			else if (pick == 1) h = 0;
			else if (pick == 2) h = $urandom_range(4097, 8191);
			else h = $urandom_range(1, 4);
			idling_on = ($urandom_range(0, 3) != 0);
			set_geometry(w, h, 1'($urandom_range(0, 1)));
			n = $urandom_range(4, 36);
			repeat (n) begin
				send_pixel(16'($urandom()));
				if ($urandom_range(0, 40) == 0) wait_drained();
			end
			sent += n;
			wait_drained();
		end
	endtask

	task automatic test_back_to_back();
		idling_on = 1'b0;
		set_geometry(5, 3, 1'b0);
		repeat (60) send_pixel(16'($urandom()));
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_color_extremes();
		test_row_padding();
		test_dimension_limits();
		test_random_frames();
		test_back_to_back();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && bytes_due.size() == 0) begin
			$display("rgb565_to_bmp24_stream_top verification clean");
		end else begin
			$display("rgb565_to_bmp24_stream_top verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/r2b_pkg.sv
sv/r2b_byte_seq.sv
sv/rgb565_to_bmp24_stream_top.sv
tb/sv/tb_rgb565_to_bmp24_stream_top.sv
